### rtl/core/kdlp_pkg.sv
// Shared types and constants for the key debouncer with long-press detection.
// No dependencies; imported by kdlp_fsm and key_debounce_long_press.
package kdlp_pkg;

  localparam int unsigned KEY_W    = 4;
  localparam int unsigned PERIOD_W = 8;

  localparam logic [PERIOD_W-1:0] LONG_PERIOD_RESET = PERIOD_W'(125);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SETTLE  = 3'd1,
    PH_CONFIRM = 3'd2,
    PH_HOLD    = 3'd3,
    PH_RELEASE = 3'd4
  } kdlp_phase_t;

  // Latched key event as seen by the reader.
  typedef struct packed {
    logic [KEY_W-1:0] keys;
    logic             is_long;
  } kdlp_event_t;

endpackage

### rtl/core/kdlp_fsm.sv
// Debounce phase machine, hold counter and event latch; one tick per step_en.
// Depends on kdlp_pkg.
module kdlp_fsm import kdlp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [KEY_W-1:0]    keys_n,
  input  logic                read_event,
  input  logic [PERIOD_W-1:0] long_period,
  output kdlp_event_t         cur_event
);

  kdlp_phase_t         phase_r, phase_nxt;
  logic [KEY_W-1:0]    first_keys_r, first_keys_nxt;
  logic [PERIOD_W-1:0] hold_count_r, hold_count_nxt;
  logic [KEY_W-1:0]    latched_keys_r, latched_keys_nxt;
  logic                latched_long_r, latched_long_nxt;

  logic [KEY_W-1:0]    pressed;
  logic                same;
  logic [PERIOD_W-1:0] count_inc;

  assign pressed   = ~keys_n;
  assign same      = (pressed != '0) && (pressed == first_keys_r);
  assign count_inc = hold_count_r + PERIOD_W'(1);

  // Report the latch as it stood before this tick.
  assign cur_event.keys    = latched_keys_r;
  assign cur_event.is_long = latched_long_r;

  always_comb begin
    phase_nxt        = phase_r;
    first_keys_nxt   = first_keys_r;
    hold_count_nxt   = hold_count_r;
    latched_keys_nxt = read_event ? '0 : latched_keys_r;
    latched_long_nxt = read_event ? 1'b0 : latched_long_r;
    unique case (phase_r)
      PH_SETTLE: begin
        phase_nxt = PH_CONFIRM;
      end
      PH_CONFIRM: begin
        if (same) begin
          latched_keys_nxt = pressed;
          latched_long_nxt = 1'b0;
          phase_nxt        = PH_HOLD;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_HOLD: begin
        if (same) begin
          if (count_inc > long_period) begin
            hold_count_nxt   = '0;
            latched_keys_nxt = pressed;
            latched_long_nxt = 1'b1;
          end else begin
            hold_count_nxt = count_inc;
          end
        end else begin
          hold_count_nxt = '0;
          phase_nxt      = PH_RELEASE;
        end
      end
      PH_RELEASE: begin
        phase_nxt = PH_IDLE;
      end
      default: begin
        if (pressed != '0) begin
          first_keys_nxt = pressed;
          phase_nxt      = PH_SETTLE;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      first_keys_r   <= '0;
      hold_count_r   <= '0;
      latched_keys_r <= '0;
      latched_long_r <= 1'b0;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      first_keys_r   <= first_keys_nxt;
      hold_count_r   <= hold_count_nxt;
      latched_keys_r <= latched_keys_nxt;
      latched_long_r <= latched_long_nxt;
    end
  end

endmodule

### rtl/core/key_debounce_long_press.sv
// Key debouncer with long-press detection: top level.
// Depends on kdlp_pkg and kdlp_fsm.
//
// Usage:
//   Each transfer on the in_ channel is one scan tick: four active-low key
//   levels (in_keys_n) and a read strobe (in_read_event). Every tick yields
//   exactly one transfer on the out_ channel carrying the pending event as it
//   stood before that tick (out_event_keys, 0 = none; out_event_long).
//   A read strobe clears the event after reporting it; an event raised in the
//   same tick still survives.
//   cfg_we/cfg_wdata write long_period; write it only with no ticks in flight.
// Timing:
//   A tick passes an input register, then the phase update and a result
//   register. Throughput is one tick per cycle while out_stall does not hold a
//   waiting result, set by the single phase/counter update per cycle.
// Stall:
//   While out_stall holds a waiting result, hold the tick in the input
//   register and raise in_stall once that register is full; no tick is lost.
// Reset: rst_n (synchronous, active low) returns the machine to idle, clears
//   the event latch and counter, and loads long_period with 125.
module key_debounce_long_press import kdlp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_wdata,
  // scan ticks
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KEY_W-1:0]    in_keys_n,
  input  logic                in_read_event,
  // events
  output logic                out_valid,
  input  logic                out_stall,
  output logic [KEY_W-1:0]    out_event_keys,
  output logic                out_event_long
);

  logic [PERIOD_W-1:0] long_period_r;

  // input register
  logic             tick_valid_r;
  logic [KEY_W-1:0] tick_keys_r;
  logic             tick_read_r;

  // result register
  logic             out_valid_r;
  kdlp_event_t      out_event_r;

  logic             step_en;
  logic             out_free;
  kdlp_event_t      cur_event;

  // Advance a tick when the result register is empty or draining.
  assign out_free = !out_valid_r || !out_stall;
  assign step_en  = tick_valid_r && out_free;
  // Hold the input side only while the input register is full and blocked.
  assign in_stall = tick_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_period_r <= LONG_PERIOD_RESET;
    end else if (cfg_we) begin
      long_period_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_valid_r <= 1'b0;
    end else if (!in_stall) begin
      tick_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      tick_keys_r <= in_keys_n;
      tick_read_r <= in_read_event;
    end
  end

  kdlp_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .keys_n      (tick_keys_r),
    .read_event  (tick_read_r),
    .long_period (long_period_r),
    .cur_event   (cur_event)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step_en;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_event_r <= cur_event;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_keys = out_event_r.keys;
  assign out_event_long = out_event_r.is_long;

`ifndef SYNTH
  // A long event always names the keys that were held.
  a_long_has_keys: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_event_long && (out_event_keys == '0)))
    else $error("long event reported with empty key set");

  // The input side is held only while a tick waits in the input register.
  a_stall_needs_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (tick_valid_r && out_valid_r))
    else $error("input stalled without a waiting tick");

  // A stalled tick in the input register must still be there next cycle.
  a_tick_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> tick_valid_r)
    else $error("stalled tick dropped from input register");
`endif

endmodule

### dv/tb_key_debounce_long_press.sv
// Testbench for key_debounce_long_press: scan ticks go in through a queued driver,
// and a predictor of the debounce machine checks every event transfer in order.
// Depends on kdlp_pkg and the key_debounce_long_press RTL.
module tb_key_debounce_long_press;
  import kdlp_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam logic [KEY_W-1:0] NO_KEYS_N  = '1;  // every key released (active low)

  typedef struct packed {
    logic [KEY_W-1:0] keys_n;
    logic             rd;
  } scan_t;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                cfg_we        = 1'b0;
  logic [PERIOD_W-1:0] cfg_wdata     = '0;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic [KEY_W-1:0]    in_keys_n     = NO_KEYS_N;
  logic                in_read_event = 1'b0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic [KEY_W-1:0]    out_event_keys;
  logic                out_event_long;

  // Ticks waiting for the driver, and events waiting for the block to report them.
  scan_t       scan_q[$];
  kdlp_event_t event_q[$];

  int          send_idle_pct   = 12;
  int          recv_idle_pct   = 85;
  int          err_cnt         = 0;
  int unsigned scans_queued    = 0;
  int unsigned cycle_cnt       = 0;
  int unsigned hold_off_left   = 0;
  bit          hold_off_done   = 1'b0;

  // Debounce machine as predicted by the testbench, plus its copy of long_period.
  kdlp_phase_t         pr_phase  = PH_IDLE;
  logic [KEY_W-1:0]    pr_first  = '0;
  logic [PERIOD_W-1:0] pr_hold   = '0;
  kdlp_event_t         pr_latch  = '0;
  logic [PERIOD_W-1:0] pr_period = LONG_PERIOD_RESET;

  key_debounce_long_press dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_keys_n      (in_keys_n),
    .in_read_event  (in_read_event),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_keys (out_event_keys),
    .out_event_long (out_event_long)
  );

  always #2 clk = ~clk;

  // Advance the predicted machine by one scan tick and return the event it reports.
  // The report shows the latch before the tick; a read clears it before the phase
  // update, so an event raised in the same tick survives the read.
  function automatic kdlp_event_t debounce_tick(input scan_t s);
    logic [KEY_W-1:0] pressed;
    logic             same;
    kdlp_event_t      shown;
    pressed = ~s.keys_n;
    same    = (pressed != '0) && (pressed == pr_first);
    shown   = pr_latch;
    if (s.rd) pr_latch = '0;
    case (pr_phase)
      PH_SETTLE: pr_phase = PH_CONFIRM;  // levels ignored while settling
      PH_CONFIRM: begin
        if (same) begin
          pr_latch.keys    = pressed;
          pr_latch.is_long = 1'b0;
          pr_phase         = PH_HOLD;
        end else begin
          pr_phase = PH_IDLE;  // empty or changed set: drop without an event
        end
      end
      PH_HOLD: begin
        if (same) begin
          pr_hold = pr_hold + 1'b1;  // 8-bit counter wraps
          if (pr_hold > pr_period) begin
            pr_hold          = '0;
            pr_latch.keys    = pressed;
            pr_latch.is_long = 1'b1;
          end
        end else begin
          pr_hold  = '0;
          pr_phase = PH_RELEASE;
        end
      end
      PH_RELEASE: pr_phase = PH_IDLE;
      default: begin
        if (pressed != '0) begin
          pr_first = pressed;
          pr_phase = PH_SETTLE;
        end else begin
          pr_phase = PH_IDLE;
        end
      end
    endcase
    return shown;
  endfunction

  // Driver: predict each tick at the edge where its transfer happens, then offer
  // the next pending tick unless the sender idles. A stalled tick is held as is.
  always @(posedge clk) begin
    scan_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        event_q.push_back(debounce_tick(scan_t'{in_keys_n, in_read_event}));
      if (!in_valid || !in_stall) begin
        if (scan_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt           = scan_q.pop_front();
          in_valid      <= 1'b1;
          in_keys_n     <= nxt.keys_n;
          in_read_event <= nxt.rd;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every event transfer with the oldest prediction and drive
  // the receiver's stall. Once, in the phase where neither side idles, hold off
  // for a long stretch so the block fills up and stalls the sender.
  always @(posedge clk) begin
    kdlp_event_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (event_q.size() == 0) begin
          $display("%0t: event transfer with no tick pending, got keys %h long %b",
                   $time, out_event_keys, out_event_long);
          err_cnt++;
        end else begin
          want = event_q.pop_front();
          if (out_event_keys !== want.keys) begin
            $display("%0t: event_keys mismatch, expected %h, got %h",
                     $time, want.keys, out_event_keys);
            err_cnt++;
          end
          if (out_event_long !== want.is_long) begin
            $display("%0t: event_long mismatch, expected %b, got %b",
                     $time, want.is_long, out_event_long);
            err_cnt++;
          end
        end
      end
      if (hold_off_left != 0) begin
        hold_off_left <= hold_off_left - 1;
        out_stall     <= 1'b1;
      end else if (!hold_off_done && send_idle_pct == 0 && recv_idle_pct == 0 && out_valid) begin
        hold_off_done <= 1'b1;
        hold_off_left <= HOLD_OFF_CYCLES;
        out_stall     <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic add_scan(input logic [KEY_W-1:0] keys_n, input logic rd);
    scan_q.push_back(scan_t'{keys_n, rd});
    scans_queued++;
  endtask

  function automatic logic draw_read(input int pct);
    return ($urandom_range(99) < pct);
  endfunction

  // Queue one press: capture, settle (sometimes bouncing), confirm, hold_ticks
  // of steady hold, then a release long enough to get back to idle.
  task automatic add_press(input logic [KEY_W-1:0] keys, input int hold_ticks);
    int i;
    add_scan(~keys, draw_read(30));
    add_scan(($urandom_range(99) < 25) ? KEY_W'($urandom) : ~keys, draw_read(30));
    add_scan(~keys, draw_read(30));
    for (i = 0; i < hold_ticks; i++)
      add_scan(~keys, draw_read(30));
    repeat ($urandom_range(2, 4))
      add_scan(($urandom_range(99) < 80) ? NO_KEYS_N : KEY_W'($urandom), draw_read(30));
  endtask

  // Queue about n_items random ticks: mostly well-formed presses with random
  // keys, hold lengths and reads; the rest noise and presses that fail confirm.
  // The first press is held long enough to raise at least one long event.
  task automatic run_random(input int n_items);
    int unsigned      target;
    int               pick;
    int               hold;
    int               per;
    logic [KEY_W-1:0] keys;
    target = scans_queued + n_items;
    per    = int'(pr_period);
    keys   = KEY_W'($urandom_range(1, 15));
    add_press(keys, (per <= 60) ? 2 * (per + 1) + $urandom_range(0, 2) : per + 2);
    while (scans_queued < target) begin
      pick = $urandom_range(99);
      keys = KEY_W'($urandom_range(1, 15));
      if (pick < 12) begin
        add_scan(KEY_W'($urandom), 1'($urandom));
      end else if (pick < 22) begin
        // confirm with a changed or empty set
        add_scan(~keys, draw_read(30));
        add_scan(KEY_W'($urandom), draw_read(30));
        add_scan(~(keys ^ KEY_W'($urandom_range(1, 15))), draw_read(30));
        add_scan(NO_KEYS_N, draw_read(30));
      end else begin
        hold = $urandom_range(99);
        if (hold < 50 || per > 40)
          hold = $urandom_range(0, 6);
        else if (hold < 80)
          hold = (per == 0) ? $urandom_range(0, 2) : per - 1 + $urandom_range(0, 3);
        else
          hold = $urandom_range(0, 2 * per + 4);
        add_press(keys, hold);
      end
    end
  endtask

  // Wait until every tick has transferred and every event has come back.
  task automatic drain();
    do @(negedge clk);
    while (scan_q.size() != 0 || in_valid || event_q.size() != 0);
  endtask

  task automatic write_long_period(input logic [PERIOD_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pr_period = value;
    @(negedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed ticks with long_period at its reset value.
    add_scan(4'b1111, 1'b0);  // idle, nothing pressed
    add_scan(4'b1110, 1'b0);  // capture enter
    add_scan(4'b1111, 1'b1);  // settle ignores the release
    add_scan(4'b1110, 1'b0);  // confirm enter: short event
    add_scan(4'b1110, 1'b0);  // hold, report enter
    add_scan(4'b1111, 1'b1);  // leave hold, read clears
    add_scan(4'b1110, 1'b0);  // release phase ignores keys
    add_scan(4'b1111, 1'b0);
    add_scan(4'b1101, 1'b0);  // capture back
    add_scan(4'b1101, 1'b1);
    add_scan(4'b1011, 1'b0);  // confirm sees a different set: no event
    add_scan(4'b0111, 1'b0);  // capture up
    add_scan(4'b1111, 1'b0);
    add_scan(4'b1111, 1'b0);  // confirm sees nothing: no event
    add_scan(4'b0000, 1'b0);  // capture every key
    add_scan(4'b0000, 1'b1);
    add_scan(4'b0000, 1'b1);  // event raised in the tick of a read survives it
    add_scan(4'b0000, 1'b1);
    add_scan(4'b0000, 1'b0);
    add_scan(4'b1010, 1'b0);  // changed set leaves hold
    add_scan(4'b1010, 1'b0);
    add_scan(4'b1010, 1'b0);  // capture the new set from idle
    add_scan(4'b1010, 1'b0);
    add_scan(4'b1010, 1'b0);  // confirm raises a short event for the new set
    add_scan(4'b1111, 1'b1);
    add_scan(4'b1111, 1'b0);

    // Sender idles a little, receiver a lot.
    run_random(150);
    drain();
    write_long_period(8'd0);
    run_random(150);
    drain();

    // Sender idles a lot, receiver a little.
    send_idle_pct <= 85;
    recv_idle_pct <= 12;
    write_long_period(8'd254);
    run_random(100);
    drain();
    write_long_period(8'd5);
    run_random(150);
    drain();

    // No idling; the monitor's long hold-off lands in here.
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    write_long_period(8'd1);
    run_random(150);
    drain();
    write_long_period(PERIOD_W'($urandom_range(2, 20)));
    run_random(200);
    drain();

    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
